>>> hw/rtl/tpe_pkg.sv
package tpe_pkg;

  // Caption store geometry and byte width.
  localparam int unsigned CapLen = 32;
  localparam int unsigned CapAw  = $clog2(CapLen);
  localparam int unsigned ByteW  = 8;

  // Byte positions inside a 45-byte packet.
  localparam logic [5:0] PosRowFirst = 6'd5;
  localparam logic [5:0] PosCapFirst = 6'd13;
  localparam logic [5:0] PosLast     = 6'd44;

  // Last index of the prefix sequence for row and header starts.
  localparam logic [3:0] SeqRowLast = 4'd4;
  localparam logic [3:0] SeqHdrLast = 4'd12;

  // Caption index of the last byte and of the first byte of the clock field.
  localparam logic [CapAw-1:0] CapLast      = CapAw'(CapLen - 1);
  localparam logic [CapAw-1:0] CapTimeFirst = CapAw'(37 - 13);

  // Number of time digits that are substituted.
  localparam logic [2:0] TimeDigits = 3'd6;

  // Largest time of day in seconds.
  localparam logic [16:0] TodMax = 17'd86399;

  // Reciprocal constants for the time split.
  localparam logic [15:0] RecipHour = 16'd37283;  // ceil(2^27 / 3600)
  localparam int unsigned ShiftHour = 27;
  localparam logic [12:0] RecipMin  = 13'd4370;   // ceil(2^18 / 60)
  localparam int unsigned ShiftMin  = 18;
  localparam logic [16:0] SecPerHour = 17'd3600;
  localparam logic [11:0] SecPerMin  = 12'd60;

  // Character constants.
  localparam logic [7:0] ChSync    = 8'h55;
  localparam logic [7:0] ChFraming = 8'h27;
  localparam logic [7:0] ChQuery   = 8'h3F;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChHexOfs  = 8'h37;
  localparam logic [7:0] ChM       = 8'h6D;
  localparam logic [7:0] ChP       = 8'h70;

  // Hamming 8/4 code words.
  localparam logic [7:0] Ham84 [16] = '{
    8'h15, 8'h02, 8'h49, 8'h5E, 8'h64, 8'h73, 8'h38, 8'h2F,
    8'hD0, 8'hC7, 8'h8C, 8'h9B, 8'hA1, 8'hB6, 8'hFD, 8'hEA
  };

  typedef enum logic [1:0] {
    FUNC_ROW  = 2'd0,
    FUNC_HDR  = 2'd1,
    FUNC_CHAR = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef struct packed {
    func_e       func;
    logic [2:0]  magazine;
    logic [4:0]  row_number;
    logic [7:0]  page_number;
    logic [12:0] subcode;
    logic [16:0] time_of_day;
    logic [7:0]  char_in;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_end;
  } out_t;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_ROW,
    MODE_HDR
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEQ,
    ST_CHAR,
    ST_CAP_RD,
    ST_CAP_PUT
  } state_e;

  typedef enum logic [1:0] {
    SEL_SEQ,
    SEL_CHAR,
    SEL_CAP
  } out_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             latch_in;
    logic             start_hdr;
    logic             ram_we;
    logic [CapAw-1:0] ram_waddr;
    logic             ram_re;
    logic [CapAw-1:0] cap_idx;
    logic [3:0]       seq_idx;
    logic             load_out;
    out_sel_e         out_sel;
    logic             out_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

  function automatic logic [7:0] ham84(input logic [3:0] n);
    return Ham84[n];
  endfunction

  function automatic logic [7:0] bit_rev(input logic [7:0] c);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = c[7-i];
    end
    return r;
  endfunction

  // Bit 7 makes the count of ones over the byte odd.
  function automatic logic [7:0] odd_par(input logic [7:0] c);
    return {~(^c[6:0]), c[6:0]};
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    return (n > 4'd9) ? ({4'b0, n} + ChHexOfs) : ({4'b0, n} + ChZero);
  endfunction

  // Tens digit of a value below 64.
  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd60) begin
      t = 3'd6;
    end else if (v >= 6'd50) begin
      t = 3'd5;
    end else if (v >= 6'd40) begin
      t = 3'd4;
    end else if (v >= 6'd30) begin
      t = 3'd3;
    end else if (v >= 6'd20) begin
      t = 3'd2;
    end else if (v >= 6'd10) begin
      t = 3'd1;
    end else begin
      t = 3'd0;
    end
    return t;
  endfunction

  function automatic logic [3:0] units_of(input logic [5:0] v);
    logic [5:0] u;
    u = v - (6'(tens_of(v)) * 6'd10);
    return u[3:0];
  endfunction

endpackage

>>> hw/rtl/teletext_packet_encoder_top.sv
// The first byte of a result enters the output register from ST_SEQ or ST_CHAR, which
// the input transfer enters, or for a caption from ST_CAP_PUT after ST_CAP_RD. Row and
// header start bytes go out at one output byte per cycle while the output register is free.
// The last caption character emits the whole caption, each byte first read (ST_CAP_RD)
// via the registered read port of the single caption memory, then put out (ST_CAP_PUT).
// Reset (rst_ni low, asynchronous) closes any open packet and empties the output register.
module teletext_packet_encoder_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tpe_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tpe_pkg::out_t out_data_o
);

  tpe_pkg::cmd_t cmd;
  tpe_pkg::sts_t sts;

  tpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_func_i  (in_data_i.func),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tpe_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hw/rtl/tpe_ram.sv
module tpe_ram #(
  parameter int unsigned Width = tpe_pkg::ByteW,
  parameter int unsigned Depth = tpe_pkg::CapLen
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/tpe_ctrl.sv
module tpe_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tpe_pkg::func_e in_func_i,
  input  tpe_pkg::sts_t  sts_i,
  output tpe_pkg::cmd_t  cmd_o
);

  tpe_pkg::state_e state_q, state_d;
  tpe_pkg::mode_e  mode_q, mode_d;
  logic [5:0] pos_q, pos_d;
  logic [3:0] seq_q, seq_d;
  logic       hdr_q, hdr_d;
  logic       char_last_q, char_last_d;
  logic [tpe_pkg::CapAw-1:0] cap_q, cap_d;

  logic       in_acc;
  logic       row_ok;
  logic       cap_ok;
  logic       pos_last;
  logic       seq_end;
  logic [5:0] cap_off;

  // The input side is open only between items.
  assign in_ready_o = (state_q == tpe_pkg::ST_IDLE);

  assign in_acc   = in_valid_i & in_ready_o;
  assign row_ok   = (mode_q == tpe_pkg::MODE_ROW) && (pos_q >= tpe_pkg::PosRowFirst) &&
                    (pos_q <= tpe_pkg::PosLast);
  assign cap_ok   = (mode_q == tpe_pkg::MODE_HDR) && (pos_q >= tpe_pkg::PosCapFirst) &&
                    (pos_q <= tpe_pkg::PosLast);
  assign pos_last = (pos_q == tpe_pkg::PosLast);
  assign seq_end  = hdr_q ? (seq_q == tpe_pkg::SeqHdrLast) : (seq_q == tpe_pkg::SeqRowLast);
  assign cap_off  = pos_q - tpe_pkg::PosCapFirst;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tpe_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_func_i)
            tpe_pkg::FUNC_ROW, tpe_pkg::FUNC_HDR: state_d = tpe_pkg::ST_SEQ;
            tpe_pkg::FUNC_CHAR: begin
              if (row_ok) begin
                state_d = tpe_pkg::ST_CHAR;
              end else if (cap_ok && pos_last) begin
                state_d = tpe_pkg::ST_CAP_RD;
              end
            end
            default: state_d = tpe_pkg::ST_IDLE;
          endcase
        end
      end
      tpe_pkg::ST_SEQ: begin
        if (sts_i.out_free && seq_end) begin
          state_d = tpe_pkg::ST_IDLE;
        end
      end
      tpe_pkg::ST_CHAR: begin
        if (sts_i.out_free) begin
          state_d = tpe_pkg::ST_IDLE;
        end
      end
      tpe_pkg::ST_CAP_RD: state_d = tpe_pkg::ST_CAP_PUT;
      tpe_pkg::ST_CAP_PUT: begin
        if (sts_i.out_free) begin
          state_d = (cap_q == tpe_pkg::CapLast) ? tpe_pkg::ST_IDLE : tpe_pkg::ST_CAP_RD;
        end
      end
      default: state_d = tpe_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o           = '0;
    cmd_o.out_sel   = tpe_pkg::SEL_SEQ;
    cmd_o.latch_in  = in_acc;
    cmd_o.start_hdr = in_acc && (in_func_i == tpe_pkg::FUNC_HDR);
    cmd_o.ram_we    = in_acc && (in_func_i == tpe_pkg::FUNC_CHAR) && !row_ok && cap_ok;
    cmd_o.ram_waddr = cap_off[tpe_pkg::CapAw-1:0];
    cmd_o.cap_idx   = cap_q;
    cmd_o.seq_idx   = seq_q;
    case (state_q)
      tpe_pkg::ST_SEQ: begin
        cmd_o.load_out = sts_i.out_free;
        cmd_o.out_sel  = tpe_pkg::SEL_SEQ;
      end
      tpe_pkg::ST_CHAR: begin
        cmd_o.load_out = sts_i.out_free;
        cmd_o.out_sel  = tpe_pkg::SEL_CHAR;
        cmd_o.out_last = char_last_q;
      end
      tpe_pkg::ST_CAP_RD: begin
        cmd_o.ram_re = 1'b1;
      end
      tpe_pkg::ST_CAP_PUT: begin
        cmd_o.load_out = sts_i.out_free;
        cmd_o.out_sel  = tpe_pkg::SEL_CAP;
        cmd_o.out_last = (cap_q == tpe_pkg::CapLast);
      end
      default: begin
        cmd_o.load_out = 1'b0;
      end
    endcase
  end

  // Packet mode, byte position and sequence counters.
  always_comb begin
    mode_d      = mode_q;
    pos_d       = pos_q;
    seq_d       = seq_q;
    hdr_d       = hdr_q;
    char_last_d = char_last_q;
    cap_d       = cap_q;
    if (in_acc) begin
      case (in_func_i)
        tpe_pkg::FUNC_ROW: begin
          mode_d = tpe_pkg::MODE_ROW;
          pos_d  = tpe_pkg::PosRowFirst;
          seq_d  = '0;
          hdr_d  = 1'b0;
        end
        tpe_pkg::FUNC_HDR: begin
          mode_d = tpe_pkg::MODE_HDR;
          pos_d  = tpe_pkg::PosCapFirst;
          seq_d  = '0;
          hdr_d  = 1'b1;
        end
        tpe_pkg::FUNC_CHAR: begin
          if (row_ok || cap_ok) begin
            char_last_d = pos_last;
            if (pos_last) begin
              mode_d = tpe_pkg::MODE_NONE;
              pos_d  = '0;
              cap_d  = '0;
            end else begin
              pos_d = pos_q + 6'd1;
            end
          end
        end
        default: mode_d = mode_q;
      endcase
    end
    if ((state_q == tpe_pkg::ST_SEQ) && sts_i.out_free) begin
      seq_d = seq_q + 4'd1;
    end
    if ((state_q == tpe_pkg::ST_CAP_PUT) && sts_i.out_free) begin
      cap_d = cap_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpe_pkg::ST_IDLE;
      mode_q      <= tpe_pkg::MODE_NONE;
      pos_q       <= '0;
      seq_q       <= '0;
      hdr_q       <= 1'b0;
      char_last_q <= 1'b0;
      cap_q       <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      pos_q       <= pos_d;
      seq_q       <= seq_d;
      hdr_q       <= hdr_d;
      char_last_q <= char_last_d;
      cap_q       <= cap_d;
    end
  end

  // An open row packet always points into the payload area.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == tpe_pkg::MODE_ROW) |->
      ((pos_q >= tpe_pkg::PosRowFirst) && (pos_q <= tpe_pkg::PosLast)))
    else $error("row packet position out of range");

  // An open header packet always points into the caption area.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == tpe_pkg::MODE_HDR) |->
      ((pos_q >= tpe_pkg::PosCapFirst) && (pos_q <= tpe_pkg::PosLast)))
    else $error("header packet position out of range");

  // The last byte of a packet closes the packet and frees the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_out && cmd_o.out_last) |=>
      ((state_q == tpe_pkg::ST_IDLE) && (mode_q == tpe_pkg::MODE_NONE)))
    else $error("packet end did not close the packet");

endmodule

>>> hw/rtl/tpe_dp.sv
module tpe_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tpe_pkg::in_t  in_data_i,
  input  logic          out_ready_i,
  input  tpe_pkg::cmd_t cmd_i,
  output tpe_pkg::sts_t sts_o,
  output logic          out_valid_o,
  output tpe_pkg::out_t out_data_o
);

  tpe_pkg::in_t  in_q;
  tpe_pkg::out_t out_q;
  logic          out_valid_q;

  logic [2:0]  held_mag_q;
  logic [7:0]  held_page_q;
  logic [16:0] held_tod_q;

  // Time split pipeline.
  logic [16:0] tod1_q;
  logic [4:0]  hrs1_q, hrs2_q, hrs3_q;
  logic [11:0] rem2_q, rem3_q;
  logic [5:0]  min3_q, min4_q;
  logic [5:0]  sec4_q;
  logic [4:0]  hrs4_q;
  logic [3:0]  hr_t_q, hr_u_q, mn_t_q, mn_u_q, sc_t_q, sc_u_q;
  logic [32:0] prod_h;
  logic [16:0] hour_sec;
  logic [16:0] rem_full;
  logic [24:0] prod_m;
  logic [11:0] min_sec;
  logic [11:0] sec_full;
  logic [16:0] tod_clamp;

  // Page number pattern tracking.
  logic [7:0]                prev1_q, prev2_q;
  logic                      match_vld_q;
  logic [tpe_pkg::CapAw-1:0] match_idx_q;
  logic                      match_hit;

  logic [2:0] dcnt_q;

  logic [7:0] ram_rdata;
  logic [4:0] row_eff;
  logic [7:0] seq_byte;
  logic [5:0] mpp_off;
  logic       in_mpp;
  logic       in_time;
  logic [7:0] cap_c1, cap_c2, cap_c3;
  logic       is_dig;
  logic [7:0] time_char;
  logic [7:0] out_byte_d;

  tpe_ram #(
    .Width (tpe_pkg::ByteW),
    .Depth (tpe_pkg::CapLen)
  ) u_cap_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (cmd_i.ram_waddr),
    .wdata_i (in_data_i.char_in),
    .re_i    (cmd_i.ram_re),
    .raddr_i (cmd_i.cap_idx),
    .rdata_o (ram_rdata)
  );

  // Input item capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      in_q <= in_data_i;
    end
  end

  assign tod_clamp = (in_data_i.time_of_day > tpe_pkg::TodMax) ? tpe_pkg::TodMax :
                     in_data_i.time_of_day;

  // Values held for the caption of a header packet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_mag_q  <= '0;
      held_page_q <= '0;
      held_tod_q  <= '0;
    end else if (cmd_i.start_hdr) begin
      held_mag_q  <= in_data_i.magazine;
      held_page_q <= in_data_i.page_number;
      held_tod_q  <= tod_clamp;
    end
  end

  // Hours and minutes by reciprocal multiplication, seconds as the remainder, one multiply per stage.
  assign prod_h   = {16'b0, held_tod_q} * {17'b0, tpe_pkg::RecipHour};
  assign hour_sec = {12'b0, hrs1_q} * tpe_pkg::SecPerHour;
  assign rem_full = tod1_q - hour_sec;
  assign prod_m   = {13'b0, rem2_q} * {12'b0, tpe_pkg::RecipMin};
  assign min_sec  = {6'b0, min3_q} * tpe_pkg::SecPerMin;
  assign sec_full = rem3_q - min_sec;

  always_ff @(posedge clk_i) begin
    tod1_q <= held_tod_q;
    hrs1_q <= prod_h[tpe_pkg::ShiftHour +: 5];
    rem2_q <= rem_full[11:0];
    hrs2_q <= hrs1_q;
    min3_q <= prod_m[tpe_pkg::ShiftMin +: 6];
    rem3_q <= rem2_q;
    hrs3_q <= hrs2_q;
    sec4_q <= sec_full[5:0];
    min4_q <= min3_q;
    hrs4_q <= hrs3_q;
    hr_t_q <= {1'b0, tpe_pkg::tens_of({1'b0, hrs4_q})};
    hr_u_q <= tpe_pkg::units_of({1'b0, hrs4_q});
    mn_t_q <= {1'b0, tpe_pkg::tens_of(min4_q)};
    mn_u_q <= tpe_pkg::units_of(min4_q);
    sc_t_q <= {1'b0, tpe_pkg::tens_of(sec4_q)};
    sc_u_q <= tpe_pkg::units_of(sec4_q);
  end

  // First page number pattern, found as the caption is stored.
  assign match_hit = !match_vld_q && (cmd_i.ram_waddr >= tpe_pkg::CapAw'(2)) &&
                     (prev2_q == tpe_pkg::ChM) && (prev1_q == tpe_pkg::ChP) &&
                     (in_data_i.char_in == tpe_pkg::ChP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_vld_q <= 1'b0;
    end else if (cmd_i.start_hdr) begin
      match_vld_q <= 1'b0;
    end else if (cmd_i.ram_we && match_hit) begin
      match_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ram_we) begin
      prev2_q <= prev1_q;
      prev1_q <= in_data_i.char_in;
      if (match_hit) begin
        match_idx_q <= cmd_i.ram_waddr - tpe_pkg::CapAw'(2);
      end
    end
  end

  // Prefix and header bytes by sequence index.
  assign row_eff = (in_q.func == tpe_pkg::FUNC_HDR) ? 5'd0 : in_q.row_number;

  always_comb begin
    case (cmd_i.seq_idx)
      4'd0, 4'd1: seq_byte = tpe_pkg::ChSync;
      4'd2:       seq_byte = tpe_pkg::ChFraming;
      4'd3:       seq_byte = tpe_pkg::ham84({row_eff[0], in_q.magazine});
      4'd4:       seq_byte = tpe_pkg::ham84(row_eff[4:1]);
      4'd5:       seq_byte = tpe_pkg::ham84(in_q.page_number[3:0]);
      4'd6:       seq_byte = tpe_pkg::ham84(in_q.page_number[7:4]);
      4'd7:       seq_byte = tpe_pkg::ham84(in_q.subcode[3:0]);
      4'd8:       seq_byte = tpe_pkg::ham84({1'b0, in_q.subcode[6:4]});
      4'd9:       seq_byte = tpe_pkg::ham84(in_q.subcode[10:7]);
      4'd10:      seq_byte = tpe_pkg::ham84({2'b0, in_q.subcode[12:11]});
      default:    seq_byte = tpe_pkg::ham84(4'h0);
    endcase
  end

  // Caption byte: page number substitution, then clock field rewrite.
  assign mpp_off = {1'b0, cmd_i.cap_idx} - {1'b0, match_idx_q};
  assign in_mpp  = match_vld_q && (cmd_i.cap_idx >= match_idx_q) && (mpp_off < 6'd3);
  assign in_time = (cmd_i.cap_idx >= tpe_pkg::CapTimeFirst);

  always_comb begin
    cap_c1 = ram_rdata;
    if (in_mpp) begin
      case (mpp_off[1:0])
        2'd0:    cap_c1 = tpe_pkg::ChZero + {5'b0, held_mag_q};
        2'd1:    cap_c1 = tpe_pkg::hex_digit(held_page_q[7:4]);
        default: cap_c1 = tpe_pkg::hex_digit(held_page_q[3:0]);
      endcase
    end
  end

  always_comb begin
    case (dcnt_q)
      3'd0:    time_char = tpe_pkg::ChZero + {4'b0, hr_t_q};
      3'd1:    time_char = tpe_pkg::ChZero + {4'b0, hr_u_q};
      3'd2:    time_char = tpe_pkg::ChZero + {4'b0, mn_t_q};
      3'd3:    time_char = tpe_pkg::ChZero + {4'b0, mn_u_q};
      3'd4:    time_char = tpe_pkg::ChZero + {4'b0, sc_t_q};
      3'd5:    time_char = tpe_pkg::ChZero + {4'b0, sc_u_q};
      default: time_char = tpe_pkg::ChQuery;
    endcase
  end

  assign cap_c2 = (in_time && (cap_c1 == tpe_pkg::ChCr)) ? tpe_pkg::ChQuery : cap_c1;
  assign is_dig = in_time && (cap_c2 >= tpe_pkg::ChZero) && (cap_c2 <= tpe_pkg::ChNine);
  assign cap_c3 = is_dig ? time_char : cap_c2;

  // Count of clock digits used so far, saturating after the seconds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.start_hdr) begin
      dcnt_q <= '0;
    end else if (cmd_i.load_out && (cmd_i.out_sel == tpe_pkg::SEL_CAP) && is_dig &&
                 (dcnt_q != tpe_pkg::TimeDigits)) begin
      dcnt_q <= dcnt_q + 3'd1;
    end
  end

  // Output byte selection.
  always_comb begin
    case (cmd_i.out_sel)
      tpe_pkg::SEL_SEQ:  out_byte_d = tpe_pkg::bit_rev(seq_byte);
      tpe_pkg::SEL_CHAR: out_byte_d = tpe_pkg::bit_rev(tpe_pkg::odd_par(in_q.char_in));
      tpe_pkg::SEL_CAP:  out_byte_d = tpe_pkg::bit_rev(tpe_pkg::odd_par(cap_c3));
      default:           out_byte_d = tpe_pkg::bit_rev(seq_byte);
    endcase
  end

  // Output register; a new byte enters when the slot is empty or being taken.
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.out_byte   <= out_byte_d;
      out_q.packet_end <= cmd_i.out_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The controller never overwrites a byte that has not been transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten before transfer");

endmodule

>>> tb/tb_teletext_packet_encoder_top.sv
module tb_teletext_packet_encoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape: idle phases change with the number of items that took effect.
  localparam int TotalUsed   = 450;
  localparam int PhaseOneAt  = 190;
  localparam int PhaseTwoAt  = 350;
  localparam int HoldAt      = 400;
  localparam int HoldCycles  = 400;
  localparam int TailCycles  = 80;
  localparam int NotTyped    = -1;

  // Standard teletext Hamming 8/4 code words, indexed by data nibble.
  localparam logic [7:0] HammingWord [16] = '{
    8'h15, 8'h02, 8'h49, 8'h5E, 8'h64, 8'h73, 8'h38, 8'h2F,
    8'hD0, 8'hC7, 8'h8C, 8'h9B, 8'hA1, 8'hB6, 8'hFD, 8'hEA
  };

  // One row of the directed stimulus table.
  typedef struct packed {
    tpe_pkg::in_t  item;
    int            reps;
    int            n_typed;
    tpe_pkg::out_t first_typed;
  } directed_row_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  tpe_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  tpe_pkg::out_t out_data_o;

  // Predicted encoder state.
  tpe_pkg::mode_e cur_mode  = tpe_pkg::MODE_NONE;
  logic [5:0]     cur_pos   = '0;
  logic [2:0]     held_mag  = '0;
  logic [7:0]     held_page = '0;
  logic [4:0]     held_hour = '0;
  logic [5:0]     held_min  = '0;
  logic [5:0]     held_sec  = '0;
  logic [7:0]     caption_store [tpe_pkg::CapLen];

  tpe_pkg::out_t packet_bytes_due [$];
  int            pushed_now;
  tpe_pkg::out_t first_new;
  bit            item_used;
  int            last_count;
  int            used_count = 0;
  int            err_count  = 0;
  int            hold_left  = 0;
  bit            hold_done  = 1'b0;

  directed_row_t directed [$];

  teletext_packet_encoder_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Phase 0: sender light, receiver heavy idling; phase 1 swapped; phase 2 none.
  function automatic int idle_phase();
    if (used_count < PhaseOneAt) begin
      return 0;
    end else if (used_count < PhaseTwoAt) begin
      return 1;
    end
    return 2;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] c);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = c[7-i];
    end
    return r;
  endfunction

  // Bit 7 is set when the low seven bits hold an even number of ones.
  function automatic logic [7:0] with_odd_parity(input logic [7:0] c);
    return {~(^c[6:0]), c[6:0]};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n > 4'd9) ? 8'(n + 8'h37) : 8'(n + tpe_pkg::ChZero);
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic last);
    tpe_pkg::out_t o;
    o.out_byte   = rev8(b);
    o.packet_end = last;
    if (pushed_now == 0) begin
      first_new = o;
    end
    packet_bytes_due.push_back(o);
    pushed_now++;
  endfunction

  function automatic void push_prefix(input logic [2:0] mag, input logic [4:0] row);
    push_byte(tpe_pkg::ChSync, 1'b0);
    push_byte(tpe_pkg::ChSync, 1'b0);
    push_byte(tpe_pkg::ChFraming, 1'b0);
    push_byte(HammingWord[{row[0], mag}], 1'b0);
    push_byte(HammingWord[row[4:1]], 1'b0);
  endfunction

  // Predicts the bytes that one accepted item causes and advances the state.
  function automatic int encode_item(input tpe_pkg::in_t it);
    logic [7:0] cap [tpe_pkg::CapLen];
    int tod;
    int digit;
    int tv [6];
    bit found;
    pushed_now = 0;
    item_used  = 1'b0;
    case (it.func)
      tpe_pkg::FUNC_ROW: begin
        push_prefix(it.magazine, it.row_number);
        cur_mode  = tpe_pkg::MODE_ROW;
        cur_pos   = tpe_pkg::PosRowFirst;
        item_used = 1'b1;
      end
      tpe_pkg::FUNC_HDR: begin
        tod = int'(it.time_of_day);
        if (tod > int'(tpe_pkg::TodMax)) begin
          tod = int'(tpe_pkg::TodMax);
        end
        held_mag  = it.magazine;
        held_page = it.page_number;
        held_sec  = 6'(tod % 60);
        held_min  = 6'((tod / 60) % 60);
        held_hour = 5'(tod / 3600);
        push_prefix(it.magazine, 5'd0);
        push_byte(HammingWord[it.page_number[3:0]], 1'b0);
        push_byte(HammingWord[it.page_number[7:4]], 1'b0);
        push_byte(HammingWord[it.subcode[3:0]], 1'b0);
        push_byte(HammingWord[{1'b0, it.subcode[6:4]}], 1'b0);
        push_byte(HammingWord[it.subcode[10:7]], 1'b0);
        push_byte(HammingWord[{2'b00, it.subcode[12:11]}], 1'b0);
        push_byte(HammingWord[0], 1'b0);
        push_byte(HammingWord[0], 1'b0);
        cur_mode  = tpe_pkg::MODE_HDR;
        cur_pos   = tpe_pkg::PosCapFirst;
        item_used = 1'b1;
      end
      tpe_pkg::FUNC_CHAR: begin
        if (cur_mode == tpe_pkg::MODE_ROW && cur_pos >= tpe_pkg::PosRowFirst &&
            cur_pos <= tpe_pkg::PosLast) begin
          item_used = 1'b1;
          push_byte(with_odd_parity(it.char_in), cur_pos == tpe_pkg::PosLast);
          if (cur_pos == tpe_pkg::PosLast) begin
            cur_mode = tpe_pkg::MODE_NONE;
            cur_pos  = '0;
          end else begin
            cur_pos++;
          end
        end else if (cur_mode == tpe_pkg::MODE_HDR && cur_pos >= tpe_pkg::PosCapFirst &&
                     cur_pos <= tpe_pkg::PosLast) begin
          item_used = 1'b1;
          caption_store[tpe_pkg::CapAw'(cur_pos - tpe_pkg::PosCapFirst)] = it.char_in;
          if (cur_pos == tpe_pkg::PosLast) begin
            cur_mode = tpe_pkg::MODE_NONE;
            cur_pos  = '0;
            for (int i = 0; i < tpe_pkg::CapLen; i++) begin
              cap[i] = caption_store[i];
            end
            // The first "mpp" becomes the magazine digit and two page digits.
            found = 1'b0;
            for (int i = 0; i + 2 < tpe_pkg::CapLen; i++) begin
              if (!found && cap[i] == tpe_pkg::ChM && cap[i+1] == tpe_pkg::ChP &&
                  cap[i+2] == tpe_pkg::ChP) begin
                cap[i]   = 8'(tpe_pkg::ChZero + held_mag);
                cap[i+1] = hex_char(held_page[7:4]);
                cap[i+2] = hex_char(held_page[3:0]);
                found    = 1'b1;
              end
            end
            // Clock field: CR turns into a query mark, digits into hh mm ss, later digits into query marks.
            tv[0] = held_hour / 10;
            tv[1] = held_hour % 10;
            tv[2] = held_min / 10;
            tv[3] = held_min % 10;
            tv[4] = held_sec / 10;
            tv[5] = held_sec % 10;
            digit = 0;
            for (int i = int'(tpe_pkg::CapTimeFirst); i < tpe_pkg::CapLen; i++) begin
              if (cap[i] == tpe_pkg::ChCr) begin
                cap[i] = tpe_pkg::ChQuery;
              end
              if (cap[i] >= tpe_pkg::ChZero && cap[i] <= tpe_pkg::ChNine) begin
                cap[i] = (digit < 6) ? 8'(tpe_pkg::ChZero + tv[digit]) : tpe_pkg::ChQuery;
                digit++;
              end
            end
            for (int i = 0; i < tpe_pkg::CapLen; i++) begin
              push_byte(with_odd_parity(cap[i]), i == tpe_pkg::CapLen - 1);
            end
          end else begin
            cur_pos++;
          end
        end
      end
      default: begin
      end
    endcase
    return pushed_now;
  endfunction

  function automatic tpe_pkg::in_t random_item();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[55:0];
  endfunction

  function automatic tpe_pkg::in_t mk(input tpe_pkg::func_e f, input logic [2:0] mag,
                                      input logic [4:0] row, input logic [7:0] page,
                                      input logic [12:0] sub, input logic [16:0] tod,
                                      input logic [7:0] ch);
    tpe_pkg::in_t it;
    it.func        = f;
    it.magazine    = mag;
    it.row_number  = row;
    it.page_number = page;
    it.subcode     = sub;
    it.time_of_day = tod;
    it.char_in     = ch;
    return it;
  endfunction

  task automatic add_row(input tpe_pkg::in_t it, input int reps, input int n_typed,
                         input logic [7:0] first_byte);
    directed_row_t r;
    r.item                   = it;
    r.reps                   = reps;
    r.n_typed                = n_typed;
    r.first_typed.out_byte   = first_byte;
    r.first_typed.packet_end = 1'b0;
    directed.push_back(r);
  endtask

  // Offers one item from a falling edge and returns at the falling edge after the transfer.
  task automatic send_item(input tpe_pkg::in_t it);
    int gap;
    int pct;
    gap = 0;
    case (idle_phase())
      0:       pct = 32;
      1:       pct = 47;
      default: pct = 0;
    endcase
    while ($urandom_range(99) < pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    last_count = encode_item(it);
    if (item_used) begin
      used_count++;
    end
    @(negedge clk_i);
  endtask

  // Receiver: random ready per phase, plus one long hold-off under full load.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else if (!hold_done && used_count >= HoldAt) begin
      hold_done   = 1'b1;
      hold_left   = HoldCycles - 1;
      out_ready_i = 1'b0;
    end else begin
      case (idle_phase())
        0:       out_ready_i = ($urandom_range(99) >= 47);
        1:       out_ready_i = ($urandom_range(99) >= 32);
        default: out_ready_i = 1'b1;
      endcase
    end
  end

  // Each output transfer is compared with the oldest predicted byte.
  always @(posedge clk_i) begin : check_output
    tpe_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (packet_bytes_due.size() == 0) begin
        $display("%0t: unexpected output, expected none, got byte %h end %b",
                 $time, out_data_o.out_byte, out_data_o.packet_end);
        err_count++;
      end else begin
        want = packet_bytes_due.pop_front();
        if (out_data_o !== want) begin
          $display("%0t: output mismatch, expected byte %h end %b, got byte %h end %b",
                   $time, want.out_byte, want.packet_end,
                   out_data_o.out_byte, out_data_o.packet_end);
          err_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_teletext_packet_encoder_top failed");
    $finish;
  end

  initial begin
    tpe_pkg::in_t  it;
    directed_row_t cur_row;
    logic [7:0]    plan [tpe_pkg::CapLen];
    int            sel;
    int            n;
    int            k;

    for (int i = 0; i < tpe_pkg::CapLen; i++) begin
      caption_store[i] = '0;
    end

    // Directed table: idle-state noise, extremes, abandon, and a full header.
    add_row(mk(tpe_pkg::FUNC_CHAR, 3'd0, 5'd0, 8'h00, 13'h0, 17'h0, 8'h41), 1, 0, 8'h00);
    add_row(mk(tpe_pkg::FUNC_NONE, 3'd7, 5'd31, 8'hFF, 13'h1FFF, 17'h1FFFF, 8'hFF),
            1, 0, 8'h00);
    add_row(mk(tpe_pkg::FUNC_ROW, 3'd0, 5'd0, 8'h00, 13'h0, 17'h0, 8'h00), 1, 5, 8'hAA);
    add_row(mk(tpe_pkg::FUNC_CHAR, 3'd0, 5'd0, 8'h00, 13'h0, 17'h0, 8'h00), 1, 1, 8'h01);
    add_row(mk(tpe_pkg::FUNC_CHAR, 3'd7, 5'd31, 8'hFF, 13'h1FFF, 17'h1FFFF, 8'hFF),
            1, 1, 8'hFE);
    add_row(mk(tpe_pkg::FUNC_ROW, 3'd7, 5'd31, 8'hFF, 13'h1FFF, 17'h1FFFF, 8'hFF),
            1, 5, 8'hAA);
    // Header abandons the open row; its time is out of range and clamps.
    add_row(mk(tpe_pkg::FUNC_HDR, 3'd7, 5'd31, 8'hFF, 13'h1FFF, 17'h1FFFF, 8'hFF),
            1, 13, 8'hAA);
    add_row(mk(tpe_pkg::FUNC_CHAR, 3'd0, 5'd0, 8'h00, 13'h0, 17'h0, tpe_pkg::ChM),
            1, 0, 8'h00);
    add_row(mk(tpe_pkg::FUNC_CHAR, 3'd0, 5'd0, 8'h00, 13'h0, 17'h0, tpe_pkg::ChP),
            1, 0, 8'h00);
    add_row(mk(tpe_pkg::FUNC_CHAR, 3'd0, 5'd0, 8'h00, 13'h0, 17'h0, tpe_pkg::ChP),
            1, 0, 8'h00);
    add_row(mk(tpe_pkg::FUNC_CHAR, 3'd0, 5'd0, 8'h00, 13'h0, 17'h0, 8'h00),
            10, NotTyped, 8'h00);
    add_row(mk(tpe_pkg::FUNC_CHAR, 3'd0, 5'd0, 8'h00, 13'h0, 17'h0, 8'h41),
            11, NotTyped, 8'h00);
    add_row(mk(tpe_pkg::FUNC_CHAR, 3'd0, 5'd0, 8'h00, 13'h0, 17'h0, tpe_pkg::ChCr),
            1, 0, 8'h00);
    for (int d = 1; d < 7; d++) begin
      add_row(mk(tpe_pkg::FUNC_CHAR, 3'd0, 5'd0, 8'h00, 13'h0, 17'h0,
                 8'(tpe_pkg::ChZero + d)), 1, NotTyped, 8'h00);
    end
    // A clock digit past hh mm ss closes the caption; magazine digit '7' leads it.
    add_row(mk(tpe_pkg::FUNC_CHAR, 3'd0, 5'd0, 8'h00, 13'h0, 17'h0, 8'h37), 1, 32, 8'hEC);
    add_row(mk(tpe_pkg::FUNC_CHAR, 3'd0, 5'd0, 8'h00, 13'h0, 17'h0, 8'h37), 1, 0, 8'h00);

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < directed.size(); r++) begin
      cur_row = directed[r];
      for (int j = 0; j < cur_row.reps; j++) begin
        send_item(cur_row.item);
        if (cur_row.n_typed != NotTyped &&
            (last_count != cur_row.n_typed ||
             (last_count > 0 && first_new !== cur_row.first_typed))) begin
          $display("%0t: table row %0d, expected %0d bytes first %h, got %0d bytes first %h",
                   $time, r, cur_row.n_typed, cur_row.first_typed.out_byte,
                   last_count, first_new.out_byte);
          err_count++;
        end
      end
    end

    // Random part: mostly complete packets with random content, some noise.
    while (used_count < TotalUsed) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        it = random_item();
        it.func = tpe_pkg::FUNC_HDR;
        k = $urandom_range(99);
        if (k < 70) begin
          it.time_of_day = 17'($urandom_range(0, 86399));
        end else if (k < 85) begin
          it.time_of_day = tpe_pkg::TodMax;
        end
        send_item(it);
        for (int i = 0; i < tpe_pkg::CapLen; i++) begin
          case ($urandom_range(9))
            0, 1, 2: plan[i] = 8'(tpe_pkg::ChZero + $urandom_range(9));
            3:       plan[i] = tpe_pkg::ChCr;
            4:       plan[i] = tpe_pkg::ChM;
            5:       plan[i] = tpe_pkg::ChP;
            default: plan[i] = 8'($urandom());
          endcase
        end
        if ($urandom_range(99) < 40) begin
          k = $urandom_range(0, tpe_pkg::CapLen - 3);
          plan[k]   = tpe_pkg::ChM;
          plan[k+1] = tpe_pkg::ChP;
          plan[k+2] = tpe_pkg::ChP;
        end
        n = ($urandom_range(99) < 12) ? $urandom_range(0, tpe_pkg::CapLen - 1) :
                                        tpe_pkg::CapLen;
        for (int i = 0; i < n; i++) begin
          it = random_item();
          it.func    = tpe_pkg::FUNC_CHAR;
          it.char_in = plan[i];
          send_item(it);
        end
      end else if (sel < 85) begin
        it = random_item();
        it.func = tpe_pkg::FUNC_ROW;
        send_item(it);
        n = ($urandom_range(99) < 12) ? $urandom_range(0, 39) : 40;
        for (int i = 0; i < n; i++) begin
          it = random_item();
          it.func = tpe_pkg::FUNC_CHAR;
          send_item(it);
        end
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          it = random_item();
          case ($urandom_range(2))
            0:       it.func = tpe_pkg::FUNC_NONE;
            1:       it.func = tpe_pkg::FUNC_CHAR;
            default: begin
            end
          endcase
          send_item(it);
        end
      end
    end

    in_valid_i = 1'b0;
    while (packet_bytes_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);

    if (err_count == 0) begin
      $display("tb_teletext_packet_encoder_top passed");
    end else begin
      $display("tb_teletext_packet_encoder_top failed");
    end
    $finish;
  end

endmodule
